[src/spq_pkg.sv]
// spq_pkg: shared types, widths and codes for the sorted priority queue
// no dependencies; imported by spq_ctrl, spq_datapath and the top level
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DATA_W = 32;
    localparam int PRIO_W = 32;
    localparam int OCC_W  = 5;
    localparam int ERR_W  = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic             load_req;
        logic             load_out;
        logic             push;
        logic             pop;
        logic [ERR_W-1:0] err;
    } spq_cmd_t;

    typedef struct packed {
        logic op;
        logic full;
        logic empty;
    } spq_status_t;

endpackage

`default_nettype wire

[src/spq_ctrl.sv]
// spq_ctrl: request sequencing, output handshake and error decisions
// depends on spq_pkg; drives commands into spq_datapath
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire spq_status_t status,
    output spq_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.err      = ERR_OK;
        cmd.load_req = (state_reg == ST_IDLE) && in_valid;
        cmd.load_out = (state_reg == ST_EXEC) && out_free;
        if (cmd.load_out)
        begin
            if (status.op == OP_PUSH)
            begin
                cmd.push = !status.full;
                cmd.err  = status.full ? ERR_FULL : ERR_OK;
            end
            else
            begin
                cmd.pop = !status.empty;
                cmd.err = status.empty ? ERR_EMPTY : ERR_OK;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_push_pop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop issued together");

    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result loaded but not presented");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !cmd.load_req))
        else $error("new request taken while one is in flight");
`endif

endmodule

`default_nettype wire

[src/spq_datapath.sv]
// spq_datapath: row of sorted entry cells with parallel compare-and-shift
// depends on spq_pkg; commanded by spq_ctrl
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire spq_cmd_t           cmd,
    output spq_status_t             status,
    input  wire logic               op,
    input  wire logic [DATA_W-1:0]  item_data,
    input  wire logic [PRIO_W-1:0]  item_priority,
    output logic                    popped_valid,
    output logic [DATA_W-1:0]       popped_data,
    output logic [PRIO_W-1:0]       popped_priority,
    output logic [DATA_W-1:0]       head_data,
    output logic [PRIO_W-1:0]       head_priority,
    output logic [DATA_W-1:0]       tail_data,
    output logic [PRIO_W-1:0]       tail_priority,
    output logic [OCC_W-1:0]        occupancy,
    output logic                    is_empty,
    output logic [ERR_W-1:0]        error_code
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic              req_op_reg;
    logic [DATA_W-1:0] req_data_reg;
    logic [PRIO_W-1:0] req_prio_reg;

    logic [DATA_W-1:0] data_reg  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_reg  [QUEUE_DEPTH];
    logic [DATA_W-1:0] data_next [QUEUE_DEPTH];
    logic [PRIO_W-1:0] prio_next [QUEUE_DEPTH];
    logic [DATA_W-1:0] up_data   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] up_prio   [QUEUE_DEPTH];
    logic [DATA_W-1:0] dn_data   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] dn_prio   [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [QUEUE_DEPTH-1:0] valid_next;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] prev_gt;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [DATA_W-1:0]      tail_data_reg;
    logic [PRIO_W-1:0]      tail_prio_reg;
    logic [DATA_W-1:0]      tail_data_next;
    logic [PRIO_W-1:0]      tail_prio_next;
    logic                   ins_at_end;
    logic                   empty_next;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    assign status.op    = req_op_reg;
    assign status.full  = valid_reg[QUEUE_DEPTH-1];
    assign status.empty = !valid_reg[0];

    // cells holding a strictly higher priority stay put on a push
    assign prev_gt    = {gt[QUEUE_DEPTH-2:0], 1'b1};
    assign ins_at_end = ~|(valid_reg & ~gt);

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign gt[i] = valid_reg[i] && (prio_reg[i] > req_prio_reg);

        if (i == 0)
        begin : g_first
            assign up_data[i] = req_data_reg;
            assign up_prio[i] = req_prio_reg;
        end
        else
        begin : g_up
            assign up_data[i] = data_reg[i-1];
            assign up_prio[i] = prio_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign dn_data[i] = data_reg[i];
            assign dn_prio[i] = prio_reg[i];
        end
        else
        begin : g_dn
            assign dn_data[i] = data_reg[i+1];
            assign dn_prio[i] = prio_reg[i+1];
        end

        always_comb
        begin
            data_next[i] = data_reg[i];
            prio_next[i] = prio_reg[i];
            if (cmd.push && !gt[i])
            begin
                if (prev_gt[i])
                begin
                    data_next[i] = req_data_reg;
                    prio_next[i] = req_prio_reg;
                end
                else
                begin
                    data_next[i] = up_data[i];
                    prio_next[i] = up_prio[i];
                end
            end
            else if (cmd.pop)
            begin
                data_next[i] = dn_data[i];
                prio_next[i] = dn_prio[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.push || cmd.pop)
            begin
                data_reg[i] <= data_next[i];
                prio_reg[i] <= prio_next[i];
            end
        end
    end

    always_comb
    begin
        valid_next     = valid_reg;
        count_next     = count_reg;
        tail_data_next = tail_data_reg;
        tail_prio_next = tail_prio_reg;
        empty_next     = !valid_reg[0];
        if (cmd.push)
        begin
            valid_next = {valid_reg[QUEUE_DEPTH-2:0], 1'b1};
            count_next = count_reg + CNT_W'(1);
            empty_next = 1'b0;
            if (ins_at_end)
            begin
                tail_data_next = req_data_reg;
                tail_prio_next = req_prio_reg;
            end
        end
        else if (cmd.pop)
        begin
            valid_next = {1'b0, valid_reg[QUEUE_DEPTH-1:1]};
            count_next = count_reg - CNT_W'(1);
            empty_next = !valid_reg[1];
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_op_reg   <= op;
            req_data_reg <= item_data;
            req_prio_reg <= item_priority;
        end
        tail_data_reg <= tail_data_next;
        tail_prio_reg <= tail_prio_next;
        if (cmd.load_out)
        begin
            popped_valid    <= cmd.pop;
            popped_data     <= cmd.pop ? data_reg[0] : '0;
            popped_priority <= cmd.pop ? prio_reg[0] : '0;
            head_data       <= empty_next ? '0 : data_next[0];
            head_priority   <= empty_next ? '0 : prio_next[0];
            tail_data       <= empty_next ? '0 : tail_data_next;
            tail_priority   <= empty_next ? '0 : tail_prio_next;
            occupancy       <= occ_wide[OCC_W-1:0];
            is_empty        <= empty_next;
            error_code      <= cmd.err;
        end
    end

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count out of step with valid cells");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (prio_reg[0] >= prio_reg[1]))
        else $error("head pair out of priority order");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (count_reg == $past(count_reg) + CNT_W'(1)) && valid_reg[0])
        else $error("push did not add an entry");
`endif

endmodule

`default_nettype wire

[src/sorted_priority_queue_core.sv]
// sorted_priority_queue_core: bounded priority queue kept sorted by descending priority
// the request is captured first, then the compare/shift result is loaded into the output register once it is free
// in_stall holds off a new request until the capture-then-compare/shift sequence of the last one is done
// the output register lets the result wait while the queue is idle; a stalled result holds
// reset (rst_n, async, active low) empties the queue at once
// depends on spq_pkg, spq_ctrl, spq_datapath
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire logic [DATA_W-1:0] item_data,
    input  wire logic [PRIO_W-1:0] item_priority,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   popped_valid,
    output logic [DATA_W-1:0]      popped_data,
    output logic [PRIO_W-1:0]      popped_priority,
    output logic [DATA_W-1:0]      head_data,
    output logic [PRIO_W-1:0]      head_priority,
    output logic [DATA_W-1:0]      tail_data,
    output logic [PRIO_W-1:0]      tail_priority,
    output logic [OCC_W-1:0]       occupancy,
    output logic                   is_empty,
    output logic [ERR_W-1:0]       error_code
);

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (op),
        .item_data       (item_data),
        .item_priority   (item_priority),
        .popped_valid    (popped_valid),
        .popped_data     (popped_data),
        .popped_priority (popped_priority),
        .head_data       (head_data),
        .head_priority   (head_priority),
        .tail_data       (tail_data),
        .tail_priority   (tail_priority),
        .occupancy       (occupancy),
        .is_empty        (is_empty),
        .error_code      (error_code)
    );

endmodule

`default_nettype wire

[dv/testbench.sv]
// testbench for sorted_priority_queue_core: random and directed push/pop requests with
// random idling on both sides, results checked against a built-in sorted-list predictor
// depends on spq_pkg and the sorted_priority_queue_core RTL
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic              popped_valid;
        logic [DATA_W-1:0] popped_data;
        logic [PRIO_W-1:0] popped_priority;
        logic [DATA_W-1:0] head_data;
        logic [PRIO_W-1:0] head_priority;
        logic [DATA_W-1:0] tail_data;
        logic [PRIO_W-1:0] tail_priority;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
        logic [ERR_W-1:0]  error_code;
    } queue_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0] item_priority;
    logic              out_valid;
    logic              out_stall;
    logic              popped_valid;
    logic [DATA_W-1:0] popped_data;
    logic [PRIO_W-1:0] popped_priority;
    logic [DATA_W-1:0] head_data;
    logic [PRIO_W-1:0] head_priority;
    logic [DATA_W-1:0] tail_data;
    logic [PRIO_W-1:0] tail_priority;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
    logic [ERR_W-1:0]  error_code;

    logic [DATA_W-1:0] held_data [DEPTH];
    logic [PRIO_W-1:0] held_prio [DEPTH];
    int                held_count;
    queue_result_t     pending_results [$];

    int fail_count;
    int cycle_count;
    bit idle_enable;
    bit hold_off_req;

    sorted_priority_queue_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .item_data       (item_data),
        .item_priority   (item_priority),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .popped_valid    (popped_valid),
        .popped_data     (popped_data),
        .popped_priority (popped_priority),
        .head_data       (head_data),
        .head_priority   (head_priority),
        .tail_data       (tail_data),
        .tail_priority   (tail_priority),
        .occupancy       (occupancy),
        .is_empty        (is_empty),
        .error_code      (error_code)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

    // sorted-list predictor: new entry goes ahead of equal or lower priorities
    function automatic queue_result_t compute_queue_result(input logic req_op,
                                                           input logic [DATA_W-1:0] d,
                                                           input logic [PRIO_W-1:0] p);
        queue_result_t r;
        int            pos;
        r = '{default: '0};
        if (req_op == OP_PUSH) begin
            if (held_count >= DEPTH) begin
                r.error_code = ERR_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] > p)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[pos] = d;
                held_prio[pos] = p;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.error_code = ERR_EMPTY;
            end else begin
                r.popped_valid    = 1'b1;
                r.popped_data     = held_data[0];
                r.popped_priority = held_prio[0];
                for (int i = 0; i + 1 < held_count; i++) begin
                    held_data[i] = held_data[i+1];
                    held_prio[i] = held_prio[i+1];
                end
                held_count--;
            end
        end
        if (held_count > 0) begin
            r.head_data     = held_data[0];
            r.head_priority = held_prio[0];
            r.tail_data     = held_data[held_count-1];
            r.tail_priority = held_prio[held_count-1];
        end
        r.occupancy = held_count[OCC_W-1:0];
        r.is_empty  = (held_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : result_monitor
        queue_result_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, head_data", head_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    check_field("popped_valid", 32'(popped_valid), 32'(want.popped_valid));
                    check_field("popped_data", popped_data, want.popped_data);
                    check_field("popped_priority", popped_priority, want.popped_priority);
                    check_field("head_data", head_data, want.head_data);
                    check_field("head_priority", head_priority, want.head_priority);
                    check_field("tail_data", tail_data, want.tail_data);
                    check_field("tail_priority", tail_priority, want.tail_priority);
                    check_field("occupancy", 32'(occupancy), 32'(want.occupancy));
                    check_field("is_empty", 32'(is_empty), 32'(want.is_empty));
                    check_field("error_code", 32'(error_code), 32'(want.error_code));
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(compute_queue_result(op, item_data, item_priority));
        end
    end

    // result side: random stall bursts, or one long hold-off on demand
    initial
    begin : receiver
        int burst;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_stall = 1'b1;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(negedge clk);
                out_stall    = 1'b0;
                hold_off_req = 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 12);
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(input logic req_op, input logic [DATA_W-1:0] d,
                                input logic [PRIO_W-1:0] p);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        op            = req_op;
        item_data     = d;
        item_priority = p;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int push_percent);
        if ($urandom_range(0, 99) < push_percent)
            send_request(OP_PUSH, pick_data(), pick_priority());
        else
            send_request(OP_POP, $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_request(OP_POP, 32'h1234_5678, 32'h8765_4321);
        send_request(OP_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_PUSH, 32'hA5A5_A5A5, 32'd5);
        send_request(OP_PUSH, 32'h0000_0001, 32'd5);
        send_request(OP_PUSH, 32'h0000_0002, 32'd5);
        send_request(OP_PUSH, 32'h0000_0003, 32'h0000_0000);
        send_request(OP_PUSH, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_request(OP_POP, '1, '1);
        send_request(OP_PUSH, 32'h8000_0001, 32'h8000_0000);
        send_request(OP_POP, '0, '0);
        send_request(OP_POP, '0, '0);
    endtask

    // randomly chosen fill, drain and mixed phases so full and empty are both hit often
    task automatic test_random_mix(input int count);
        int push_percent;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_percent = 85;
                    1:       push_percent = 20;
                    default: push_percent = 55;
                endcase
            end
            send_random(push_percent);
        end
    endtask

    task automatic test_receiver_hold_off();
        bit saved_idle;
        saved_idle   = idle_enable;
        idle_enable  = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_random(70);
        idle_enable = saved_idle;
    endtask

    task automatic test_steady_flow(input int count);
        idle_enable = 1'b0;
        for (int i = 0; i < count; i++)
            send_random(i < count / 2 ? 75 : 30);
    endtask

    initial
    begin : main
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_PUSH;
        item_data     = '0;
        item_priority = '0;
        idle_enable   = 1'b1;
        hold_off_req  = 1'b0;
        fail_count    = 0;
        held_count    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_mix(280);
        test_receiver_hold_off();
        test_random_mix(20);
        test_steady_flow(60);
        in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** sorted_priority_queue_core: PASSED **");
        else
            $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue_core.sv
dv/testbench.sv
